// ===== hdl/awt_pkg.sv =====
// Shared types and constants for the adaptive wavelet threshold block.
`timescale 1ns / 1ps

package awt_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 15;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_SHIFT_K = 2'd0;
	localparam cfg_idx_t CFG_GAIN_C  = 2'd1;
	localparam cfg_idx_t CFG_MODE    = 2'd2;

	localparam logic MODE_SOFT = 1'b0;
	localparam logic MODE_HARD = 1'b1;

	localparam logic [3:0]  SHIFT_K_RESET = 4'd4;
	localparam logic [14:0] GAIN_C_RESET  = 15'd16384;

	// Load and clear strobes for one leaky integrator.
	typedef struct packed {
		logic load;
		logic clear;
	} acc_ctrl_t;

endpackage

// ===== hdl/awt_leaky.sv =====
// Leaky integrator: saturating accumulator and its shifted average.
`timescale 1ns / 1ps

module awt_leaky (
	input  logic                clk,
	input  logic                arst_n,
	input  awt_pkg::acc_ctrl_t  ctrl,
	input  logic signed [15:0]  x,
	input  logic [3:0]          shift,
	output logic signed [31:0]  acc,
	output logic signed [15:0]  avg
);

	logic signed [31:0] acc_q;
	logic signed [31:0] acc_shr;
	logic signed [32:0] kept_w;
	logic signed [31:0] kept;
	logic signed [32:0] sum_w;
	logic signed [31:0] acc_next;

	always_comb begin
		acc_shr = acc_q >>> shift;
		kept_w  = {acc_q[31], acc_q} - {acc_shr[31], acc_shr};
		if (kept_w[32] != kept_w[31]) begin
			kept = kept_w[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			kept = kept_w[31:0];
		end
		sum_w = {{17{x[15]}}, x} + {kept[31], kept};
		if (sum_w[32] != sum_w[31]) begin
			acc_next = sum_w[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			acc_next = sum_w[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.load) begin
			acc_q <= ctrl.clear ? 32'sd0 : acc_next;
		end
	end

	// Average of the stored accumulator, clamped to 16 bits.
	always_comb begin
		if (acc_shr > 32'sd32767) begin
			avg = 16'sh7fff;
		end else if (acc_shr < -32'sd32768) begin
			avg = 16'sh8000;
		end else begin
			avg = acc_shr[15:0];
		end
	end

	assign acc = acc_q;

endmodule

// ===== hdl/adaptive_wavelet_threshold.sv =====
// Adaptive wavelet threshold: top level with the sample pipeline and config registers.
// Takes one coefficient word per clock while in_ready is high and gives one result word per
// accepted word. Five register stages: the mean integrator, the deviation input, the deviation
// integrator, the gain multiply, and the shrink stage that feeds the output register. Each
// integrator closes its loop through its own accumulator register, which sets the
// one-word-per-clock rate. Stalls back up stage by stage, so empty stages keep taking words
// while a result waits at the output. Configuration writes are taken at once (cfg_ready stays
// high); write them only while the pipeline is empty.
`timescale 1ns / 1ps

module adaptive_wavelet_threshold (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [awt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [awt_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [15:0]                  sample,
	input  logic                                block_start,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [15:0]                  result,
	output logic signed [15:0]                  threshold_used
);

	// Configuration registers
	logic [3:0]  shift_q;
	logic [14:0] gain_q;
	logic        mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= awt_pkg::SHIFT_K_RESET;
			gain_q  <= awt_pkg::GAIN_C_RESET;
			mode_q  <= awt_pkg::MODE_SOFT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				awt_pkg::CFG_SHIFT_K: shift_q <= cfg_data[3:0];
				awt_pkg::CFG_GAIN_C:  gain_q  <= cfg_data[14:0];
				awt_pkg::CFG_MODE:    mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage valids and ready chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5     = !out_valid || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) out_valid <= v_s4;
		end
	end

	// Payload registers
	logic signed [15:0] x_s1, x_s2, x_s3, x_s4;
	logic               start_s1, start_s2;
	logic [14:0]        diff_s2;
	logic [14:0]        lambda_s4;

	// Mean integrator, updated as a word enters stage 1
	awt_pkg::acc_ctrl_t mean_ctrl;
	logic signed [31:0] mean_acc;
	logic signed [15:0] mean;

	assign mean_ctrl.load  = in_valid && in_ready;
	assign mean_ctrl.clear = block_start;

	awt_leaky u_mean (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mean_ctrl),
		.x      (sample),
		.shift  (shift_q),
		.acc    (mean_acc),
		.avg    (mean)
	);

	// Distance from the mean, clamped to 15 bits
	logic signed [16:0] delta;
	logic [16:0]        dist_mag;
	logic [14:0]        diff_c;

	always_comb begin
		delta    = {x_s1[15], x_s1} - {mean[15], mean};
		dist_mag = delta[16] ? 17'(-delta) : 17'(delta);
		diff_c   = (dist_mag > 17'd32767) ? 15'h7fff : dist_mag[14:0];
	end

	// Deviation integrator, updated as a word enters stage 3
	awt_pkg::acc_ctrl_t dev_ctrl;
	logic signed [31:0] dev_acc;
	logic signed [15:0] dev;

	assign dev_ctrl.load  = v_s2 && rdy3;
	assign dev_ctrl.clear = start_s2;

	awt_leaky u_dev (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dev_ctrl),
		.x      ({1'b0, diff_s2}),
		.shift  (shift_q),
		.acc    (dev_acc),
		.avg    (dev)
	);

	// Threshold: (dev * gain) >> 15, dev never negative
	logic [29:0] prod;

	assign prod = dev[14:0] * gain_q;

	// Shrink against the threshold
	logic signed [16:0] xe;
	logic [16:0]        mag;
	logic signed [17:0] excess;
	logic [16:0]        kept_mag;
	logic [16:0]        kept_neg;
	logic signed [15:0] res_c;

	always_comb begin
		xe       = {x_s4[15], x_s4};
		mag      = xe[16] ? 17'(-xe) : 17'(xe);
		excess   = $signed({1'b0, mag}) - $signed({3'b000, lambda_s4});
		kept_mag = excess[17] ? 17'd0 : excess[16:0];
		kept_neg = 17'(-kept_mag);
		unique case (mode_q)
			awt_pkg::MODE_HARD: res_c = (mag > {2'b00, lambda_s4}) ? x_s4 : 16'sd0;
			awt_pkg::MODE_SOFT: res_c = x_s4[15] ? kept_neg[15:0] : kept_mag[15:0];
			default:            res_c = x_s4;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			x_s1     <= sample;
			start_s1 <= block_start;
		end
		if (rdy2) begin
			x_s2     <= x_s1;
			start_s2 <= start_s1;
			diff_s2  <= diff_c;
		end
		if (rdy3) begin
			x_s3 <= x_s2;
		end
		if (rdy4) begin
			x_s4      <= x_s3;
			lambda_s4 <= prod[29:15];
		end
		if (rdy5) begin
			result         <= res_c;
			threshold_used <= {1'b0, lambda_s4};
		end
	end

	// A block start leaves the mean integrator at zero
	a_mean_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && block_start |=> mean_acc == 32'sd0)
		else $error("mean accumulator not cleared on block start");

	// A block start reaching the deviation integrator leaves it at zero
	a_dev_clear: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && rdy3 && start_s2 |=> dev_acc == 32'sd0)
		else $error("deviation accumulator not cleared on block start");

	// The deviation integrator only ever sums magnitudes
	a_dev_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> !dev_acc[31] && !dev[15])
		else $error("deviation went negative");

	// Input stalls only when every stage is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && v_s3 && v_s4 && out_valid && !out_ready)
		else $error("input stalled with a free stage");

endmodule
